// ===== rtl/drq_pkg.sv =====
// Shared types and constants for the disk request queue and CHS issuer.
package drq_pkg;

	localparam int SECTOR_W = 24;
	localparam int TAG_W    = 8;
	localparam int STATUS_W = 8;
	localparam int SPT_W    = 8;
	localparam int HEADS_W  = 5;
	localparam int CYL_W    = 10;
	localparam int HEAD_W   = 4;

	// Drive status check: ready plus seek complete, nothing else among the masked bits
	localparam logic [STATUS_W-1:0] STATUS_MASK = 8'hF1;
	localparam logic [STATUS_W-1:0] STATUS_GOOD = 8'h50;

	// Register indexes (address bit 2)
	localparam logic REG_SPT   = 1'b0;
	localparam logic REG_HEADS = 1'b1;

	localparam logic [SPT_W-1:0]   SPT_RESET   = 8'd63;
	localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV_SEC,
		ST_DIV_TRK,
		ST_DONE
	} state_t;

	// One queued request
	typedef struct packed {
		logic                wr;
		logic [SECTOR_W-1:0] sector;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	// One result beat, first member in the highest bits
	typedef struct packed {
		logic              drive_error;
		logic [TAG_W-1:0]  completed_tag;
		logic              completed;
		logic [SPT_W-1:0]  issue_sector;
		logic [HEAD_W-1:0] issue_head;
		logic [CYL_W-1:0]  issue_cylinder;
		logic              issue_write;
		logic              issued;
		logic              accepted;
	} result_t;

	typedef struct packed {
		logic                start;
		logic [SECTOR_W-1:0] dividend;
		logic [SPT_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                busy;
		logic                done;
		logic [SECTOR_W-1:0] quotient;
		logic [SPT_W-1:0]    remainder;
	} div_rsp_t;

endpackage

// ===== rtl/drq_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both geometry divisions.
module drq_div (
	input  logic               clk,
	input  logic               arst_n,
	input  drq_pkg::div_req_t  req,
	output drq_pkg::div_rsp_t  rsp
);

	localparam int DIV_STEPS = drq_pkg::SECTOR_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [drq_pkg::SECTOR_W-1:0]  quot_q;
	logic [drq_pkg::SPT_W-1:0]     rem_q;
	logic [drq_pkg::SPT_W-1:0]     div_q;

	logic [drq_pkg::SPT_W:0]       shifted;
	logic [drq_pkg::SPT_W:0]       diff;
	logic                          ge;

	// Shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quot_q[drq_pkg::SECTOR_W-1]};
		diff    = shifted - {1'b0, div_q};
		ge      = (shifted >= {1'b0, div_q});
	end

	// Control: run for one step per dividend bit, then pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Datapath: quotient bits replace dividend bits as they shift out
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[drq_pkg::SECTOR_W-2:0], ge};
			rem_q  <= ge ? diff[drq_pkg::SPT_W-1:0] : shifted[drq_pkg::SPT_W-1:0];
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/disk_request_queue_chs_issuer_core.sv =====
// Disk request queue with one outstanding command and CHS conversion on issue.
// When nothing is issued, the result is built on the input beat and then loaded into the
// output register; when a request is issued, the steps are a memory read, a load, two passes
// of the shared bit-serial divider for sector/spt and track/heads, result, output register.
// One item at a time: the next input beat is taken once the result is in the output register.
// Reset clears pointers, count, outstanding flag and tag; queue memory has no reset.
module disk_request_queue_chs_issuer_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // write_request, lba[23:0], request_tag[7:0],
	                              // drive_status[7:0], zero pad
	input  logic        s_tuser,  // op
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // accepted, issued, issue_write, issue_cylinder[9:0],
	                              // issue_head[3:0], issue_sector[7:0], completed,
	                              // completed_tag[7:0], drive_error, zero pad
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RES_W = $bits(drq_pkg::result_t);

	drq_pkg::state_t    state_q, state_d;

	logic [drq_pkg::SPT_W-1:0]   spt_q;
	logic [drq_pkg::HEADS_W-1:0] heads_q;
	logic [drq_pkg::SPT_W-1:0]   spt_eff;
	logic [drq_pkg::HEADS_W-1:0] heads_eff;

	logic [PTR_W-1:0]            rptr_q, wptr_q;
	logic [CNT_W-1:0]            count_q;
	logic                        outstanding_q;
	logic [drq_pkg::TAG_W-1:0]   current_tag_q;

	drq_pkg::entry_t             fifo_mem [QUEUE_DEPTH];
	drq_pkg::entry_t             rd_data_q;
	drq_pkg::entry_t             wr_entry;

	drq_pkg::result_t            res_q;
	drq_pkg::result_t            res_d;
	drq_pkg::result_t            out_q;
	logic                        out_valid_q;

	drq_pkg::div_req_t           div_req;
	drq_pkg::div_rsp_t           div_rsp;

	logic                        in_op;
	logic [drq_pkg::STATUS_W-1:0] in_status;
	logic                        accept;
	logic                        full;
	logic                        push;
	logic                        complete;
	logic                        dispatch;
	logic                        rd_en;
	logic                        out_load;
	logic                        cfg_wr;

	// Unpack the input beat
	always_comb begin
		in_op           = s_tuser;
		wr_entry.wr     = s_tdata[0];
		wr_entry.sector = s_tdata[24:1];
		wr_entry.tag    = s_tdata[32:25];
		in_status       = s_tdata[40:33];
	end

	// Decode what the accepted beat does
	always_comb begin
		accept    = s_tvalid && s_tready;
		full      = (count_q == CNT_W'(QUEUE_DEPTH));
		push      = !in_op && !full;
		complete  = in_op && outstanding_q;
		dispatch  = push ? !outstanding_q : (complete && (count_q != '0));
		spt_eff   = (spt_q == '0) ? drq_pkg::SPT_W'(1) : spt_q;
		heads_eff = (heads_q == '0) ? drq_pkg::HEADS_W'(1) : heads_q;
		out_load  = (state_q == drq_pkg::ST_DONE) && (!out_valid_q || m_tready);
		cfg_wr    = psel && penable && pwrite && pready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drq_pkg::ST_IDLE: begin
				if (accept) state_d = dispatch ? drq_pkg::ST_READ : drq_pkg::ST_DONE;
			end
			drq_pkg::ST_READ:    state_d = drq_pkg::ST_LOAD;
			drq_pkg::ST_LOAD:    state_d = drq_pkg::ST_DIV_SEC;
			drq_pkg::ST_DIV_SEC: begin
				if (div_rsp.done) state_d = drq_pkg::ST_DIV_TRK;
			end
			drq_pkg::ST_DIV_TRK: begin
				if (div_rsp.done) state_d = drq_pkg::ST_DONE;
			end
			drq_pkg::ST_DONE: begin
				if (out_load) state_d = drq_pkg::ST_IDLE;
			end
			default:             state_d = drq_pkg::ST_IDLE;
		endcase
	end

	// State-driven controls
	always_comb begin
		s_tready         = (state_q == drq_pkg::ST_IDLE);
		rd_en            = (state_q == drq_pkg::ST_READ);
		div_req.start    = (state_q == drq_pkg::ST_LOAD) ||
		                   ((state_q == drq_pkg::ST_DIV_SEC) && div_rsp.done);
		if (state_q == drq_pkg::ST_LOAD) begin
			div_req.dividend = rd_data_q.sector;
			div_req.divisor  = spt_eff;
		end else begin
			div_req.dividend = div_rsp.quotient;
			div_req.divisor  = {{(drq_pkg::SPT_W - drq_pkg::HEADS_W){1'b0}}, heads_eff};
		end
	end

	drq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Queue memory: write on push, registered read at the read pointer
	always_ff @(posedge clk) begin
		if (accept && push) fifo_mem[wptr_q] <= wr_entry;
		if (rd_en) rd_data_q <= fifo_mem[rptr_q];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= drq_pkg::ST_IDLE;
			rptr_q        <= '0;
			wptr_q        <= '0;
			count_q       <= '0;
			outstanding_q <= 1'b0;
			current_tag_q <= '0;
			out_valid_q   <= 1'b0;
			spt_q         <= drq_pkg::SPT_RESET;
			heads_q       <= drq_pkg::HEADS_RESET;
		end else begin
			state_q <= state_d;
			if (accept && push) begin
				wptr_q  <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (accept && complete) outstanding_q <= 1'b0;
			// pop the oldest request and mark it outstanding
			if (rd_en) begin
				rptr_q        <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
				count_q       <= count_q - 1'b1;
				outstanding_q <= 1'b1;
			end
			if (state_q == drq_pkg::ST_LOAD) current_tag_q <= rd_data_q.tag;
			// hold the result beat until taken
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (paddr[2])
					drq_pkg::REG_SPT:   spt_q   <= pwdata[drq_pkg::SPT_W-1:0];
					drq_pkg::REG_HEADS: heads_q <= pwdata[drq_pkg::HEADS_W-1:0];
				endcase
			end
		end
	end

	// Build the result fields as the work proceeds
	always_comb begin
		res_d = res_q;
		if (accept) begin
			res_d           = '0;
			res_d.accepted  = push;
			res_d.completed = complete;
			if (complete) begin
				res_d.completed_tag = current_tag_q;
				res_d.drive_error   = ((in_status & drq_pkg::STATUS_MASK) != drq_pkg::STATUS_GOOD);
			end
		end
		if (state_q == drq_pkg::ST_LOAD) begin
			res_d.issued      = 1'b1;
			res_d.issue_write = rd_data_q.wr;
		end
		if ((state_q == drq_pkg::ST_DIV_SEC) && div_rsp.done) begin
			res_d.issue_sector = div_rsp.remainder + 1'b1;
		end
		if ((state_q == drq_pkg::ST_DIV_TRK) && div_rsp.done) begin
			res_d.issue_head     = div_rsp.remainder[drq_pkg::HEAD_W-1:0];
			res_d.issue_cylinder = div_rsp.quotient[drq_pkg::CYL_W-1:0];
		end
	end

	// Hold the result under construction and load the output register
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (out_load) out_q <= res_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(40 - RES_W){1'b0}}, out_q};
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == drq_pkg::REG_HEADS) ?
	                  {{(32 - drq_pkg::HEADS_W){1'b0}}, heads_q} :
	                  {{(32 - drq_pkg::SPT_W){1'b0}}, spt_q};

	// Queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A command becomes outstanding only through a pop
	a_outstanding_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(outstanding_q) |-> $past(state_q == drq_pkg::ST_READ))
		else $error("outstanding set without a pop");

	// The divider runs only during the two geometry divisions
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == drq_pkg::ST_DIV_SEC || state_q == drq_pkg::ST_DIV_TRK))
		else $error("divider busy outside division states");

	// An issue follows either a queued add or a completion
	a_issue_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.issued) |-> (out_q.accepted || out_q.completed))
		else $error("issue without add or completion");

endmodule

// ===== tb/tb_disk_request_queue_chs_issuer_core.sv =====
// Self-checking testbench for the disk request queue and CHS command issuer.
module tb_disk_request_queue_chs_issuer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 16;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 220;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_PHASE   = 2;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_DONE = 1'b1;

	typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;  // write_request, lba[23:0], request_tag[7:0],
	                       // drive_status[7:0], zero pad
	logic        s_tuser;  // op
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // accepted, issued, issue_write, issue_cylinder[9:0],
	                       // issue_head[3:0], issue_sector[7:0], completed,
	                       // completed_tag[7:0], drive_error, zero pad
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int cycles = 0;
	bit idling = 1'b1;
	bit tx_gaps = 1'b1;
	int rx_hold = 0;

	// Queue and issuer prediction plus the store of results still due
	class chs_issue_scoreboard;
		drq_pkg::entry_t                queued[$];
		drq_pkg::result_t               results_due[$];
		bit                             drive_busy;
		logic [drq_pkg::TAG_W-1:0]      drive_tag;
		logic [drq_pkg::SPT_W-1:0]      spt;
		logic [drq_pkg::HEADS_W-1:0]    heads;
		int                             mismatches;

		function new();
			drive_busy = 1'b0;
			drive_tag = '0;
			spt = drq_pkg::SPT_RESET;
			heads = drq_pkg::HEADS_RESET;
			mismatches = 0;
		endfunction

		function void set_geometry(logic [drq_pkg::SPT_W-1:0] s,
				logic [drq_pkg::HEADS_W-1:0] h);
			spt = s;
			heads = h;
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction

		function int backlog();
			return queued.size();
		endfunction

		// Hand the oldest request to the drive and fill in its CHS address
		function void issue_next(inout drq_pkg::result_t r);
			int unsigned s, h, trk, cyl, hd;
			drq_pkg::entry_t e;
			if (drive_busy || queued.size() == 0)
				return;
			e = queued.pop_front();
			s = (spt == 0) ? 1 : spt;
			h = (heads == 0) ? 1 : heads;
			trk = e.sector / s;
			hd = trk % h;
			cyl = trk / h;
			drive_busy = 1'b1;
			drive_tag = e.tag;
			r.issued = 1'b1;
			r.issue_write = e.wr;
			r.issue_cylinder = cyl[drq_pkg::CYL_W-1:0];
			r.issue_head = hd[drq_pkg::HEAD_W-1:0];
			r.issue_sector = drq_pkg::SPT_W'((e.sector % s) + 1);
		endfunction

		function void note_request_beat(logic op, logic wr,
				logic [drq_pkg::SECTOR_W-1:0] sector,
				logic [drq_pkg::TAG_W-1:0] tag, logic [drq_pkg::STATUS_W-1:0] status);
			drq_pkg::result_t r;
			drq_pkg::entry_t e;
			r = '0;
			if (op == OP_ADD) begin
				if (queued.size() < DEPTH) begin
					e.wr = wr;
					e.sector = sector;
					e.tag = tag;
					queued.push_back(e);
					r.accepted = 1'b1;
					issue_next(r);
				end
			end else if (drive_busy) begin
				drive_busy = 1'b0;
				r.completed = 1'b1;
				r.completed_tag = drive_tag;
				r.drive_error = ((status & drq_pkg::STATUS_MASK) != drq_pkg::STATUS_GOOD);
				issue_next(r);
			end
			results_due.push_back(r);
		endfunction

		task log_mismatch(string msg);
			mismatches++;
			$display("[%0t] MISMATCH %s", $realtime, msg);
		endtask

		task cmp_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				log_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
		endtask

		task check_result_beat(drq_pkg::result_t got);
			drq_pkg::result_t want;
			if (results_due.size() == 0) begin
				log_mismatch($sformatf("result beat %h with none due", got));
				return;
			end
			want = results_due.pop_front();
			cmp_field("accepted", 32'(got.accepted), 32'(want.accepted));
			cmp_field("issued", 32'(got.issued), 32'(want.issued));
			cmp_field("issue_write", 32'(got.issue_write), 32'(want.issue_write));
			cmp_field("issue_cylinder", 32'(got.issue_cylinder), 32'(want.issue_cylinder));
			cmp_field("issue_head", 32'(got.issue_head), 32'(want.issue_head));
			cmp_field("issue_sector", 32'(got.issue_sector), 32'(want.issue_sector));
			cmp_field("completed", 32'(got.completed), 32'(want.completed));
			cmp_field("completed_tag", 32'(got.completed_tag), 32'(want.completed_tag));
			cmp_field("drive_error", 32'(got.drive_error), 32'(want.drive_error));
		endtask
	endclass

	chs_issue_scoreboard sb = new();

	disk_request_queue_chs_issuer_core #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Check every result beat taken from the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result_beat(
				drq_pkg::result_t'(m_tdata[$bits(drq_pkg::result_t)-1:0]));
	end

	// Result side: random stalls, quiet stretches and one long hold-off
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// Offer one beat, hold it until taken, then maybe leave a gap
	task automatic send_beat(logic op, logic wr, logic [drq_pkg::SECTOR_W-1:0] sector,
			logic [drq_pkg::TAG_W-1:0] tag, logic [drq_pkg::STATUS_W-1:0] status);
		s_tuser <= op;
		s_tdata <= {7'b0, status, tag, sector, wr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request_beat(op, wr, sector, tag, status);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic apb_write(logic idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop offering and wait until every result due has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Sector numbers: low range, track and cylinder edges, or anywhere
	function automatic logic [drq_pkg::SECTOR_W-1:0] pick_sector();
		int unsigned span;
		span = (sb.spt == 0 ? 1 : sb.spt) * (sb.heads == 0 ? 1 : sb.heads);
		case ($urandom_range(0, 3))
			0: return drq_pkg::SECTOR_W'($urandom_range(0, 4095));
			1: return drq_pkg::SECTOR_W'(span * $urandom_range(0, 1100) +
			          $urandom_range(0, 1) * (span - 1));
			default: return drq_pkg::SECTOR_W'($urandom());
		endcase
	endfunction

	// Half good status with random ignored bits, half anything
	function automatic logic [drq_pkg::STATUS_W-1:0] pick_status();
		if ($urandom_range(0, 1))
			return drq_pkg::STATUS_W'(drq_pkg::STATUS_GOOD |
			       ($urandom() & ~drq_pkg::STATUS_MASK));
		return drq_pkg::STATUS_W'($urandom());
	endfunction

	// Bursts of adds that overflow the queue, drains, and mixed traffic
	task automatic run_traffic(int n);
		int sent, len, pick;
		burst_kind_t kind;
		logic op;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 5);
			kind = (sent == 0 || pick == 0) ? BURST_FILL :
			       (pick == 1) ? BURST_DRAIN : BURST_MIXED;
			tx_gaps = idling && ($urandom_range(0, 3) != 0);
			case (kind)
				BURST_FILL:  len = DEPTH + $urandom_range(2, 6);
				BURST_DRAIN: len = sb.backlog() + 2;
				default:     len = $urandom_range(4, 24);
			endcase
			repeat (len) begin
				case (kind)
					BURST_FILL:  op = OP_ADD;
					BURST_DRAIN: op = OP_DONE;
					default:     op = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_DONE;
				endcase
				send_beat(op, 1'($urandom_range(0, 1)), pick_sector(),
				          drq_pkg::TAG_W'($urandom()), pick_status());
			end
			sent += len;
		end
	endtask

	initial begin
		logic [drq_pkg::SPT_W-1:0]   spt_set[PHASES];
		logic [drq_pkg::HEADS_W-1:0] heads_set[PHASES];
		spt_set   = '{8'd63, 8'd1, 8'd255, 8'd0, 8'd255, 8'd17, 8'd9};
		heads_set = '{5'd16, 5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd2};

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_ADD;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle completion, field extremes, status decoding, wraps
		send_beat(OP_DONE, 1'b1, '1, '1, drq_pkg::STATUS_GOOD);
		send_beat(OP_ADD, 1'b0, '0, '0, '1);
		send_beat(OP_ADD, 1'b1, '1, '1, '0);
		send_beat(OP_DONE, 1'b0, '0, '0, drq_pkg::STATUS_GOOD);
		send_beat(OP_DONE, 1'b1, '1, '1, 8'hFF);
		send_beat(OP_DONE, 1'b0, '0, '0, 8'h00);
		send_beat(OP_ADD, 1'b1, 24'd62, 8'h5A, 8'h00);
		send_beat(OP_DONE, 1'b0, '0, '0, 8'h51);
		send_beat(OP_ADD, 1'b0, 24'd1007, 8'hA5, 8'hFF);
		send_beat(OP_DONE, 1'b1, '1, '1, 8'hD0);
		send_beat(OP_ADD, 1'b0, 24'd1032192, 8'h01, 8'h50);
		send_beat(OP_DONE, 1'b0, '0, '0, 8'h70);
		send_beat(OP_ADD, 1'b1, 24'd1008, 8'h80, 8'h00);
		send_beat(OP_DONE, 1'b0, '0, '0, 8'h5E);
		send_beat(OP_DONE, 1'b1, '1, '1, 8'h00);

		// Random traffic across several geometries
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				apb_write(drq_pkg::REG_SPT,
				          {24'($urandom_range(0, 2**24 - 1)), spt_set[p]});
				apb_write(drq_pkg::REG_HEADS,
				          {27'($urandom_range(0, 2**27 - 1)), heads_set[p]});
				sb.set_geometry(spt_set[p], heads_set[p]);
			end
			if (p == PHASES - 1)
				idling = 1'b0;
			if (p == HOLD_PHASE)
				rx_hold = LONG_HOLD;
			run_traffic(PHASE_ITEMS);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
